@@ rtl/fml_pkg.sv @@
// ----------------------------------------------------------------------------
// fml_pkg: shared types and constants of the fringe minimum locator
// Sequencer states, the shared multiplier request and status, the Cramer
// micro-operation table and the matrix layouts of the three determinants.
// ----------------------------------------------------------------------------
`default_nettype none

package fml_pkg;

    localparam int PROD_W = 128;
    localparam int SUM_W  = 64;
    localparam int LOWC_W = 10;

    localparam logic [LOWC_W-1:0] LOWC_MAX = '1;
    localparam logic [63:0]       MAG_LIM  = 64'd17592186044416;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_HIGH   = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_MINRUN = 2'd2;

    // Matrix layouts, m8 in the top bits down to m0 in the low bits; each
    // entry names a snapshot sum.
    localparam logic [26:0] MAT_D  = {3'd0, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd2, 3'd3, 3'd4};
    localparam logic [26:0] MAT_DA = {3'd0, 3'd1, 3'd5, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd7};
    localparam logic [26:0] MAT_DB = {3'd0, 3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd2, 3'd7, 3'd4};

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC_MUL,
        S_FIT_LA,
        S_FIT_LB,
        S_FIT_MUL,
        S_CHK,
        S_DIV,
        S_CLAMP,
        S_FRAC,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_T_LOAD,
        OP_T_SUB,
        OP_ACC_LOAD,
        OP_ACC_SUB,
        OP_ACC_ADD
    } t_op;

    typedef struct packed {
        logic       a_is_t;
        logic [3:0] a_pos;
        logic [3:0] b_pos;
        t_op        op;
    } t_uop;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] a;
        logic [SUM_W-1:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PROD_W-1:0] prod;
    } t_mul_sts;

    // One cofactor expansion along the first row, nine multiplies per matrix.
    function automatic t_uop fml_uop(input logic [3:0] ph);
        t_uop u;
        case (ph)
            4'd0:    u = '{1'b0, 4'd4, 4'd8, OP_T_LOAD};
            4'd1:    u = '{1'b0, 4'd5, 4'd7, OP_T_SUB};
            4'd2:    u = '{1'b1, 4'd0, 4'd0, OP_ACC_LOAD};
            4'd3:    u = '{1'b0, 4'd3, 4'd8, OP_T_LOAD};
            4'd4:    u = '{1'b0, 4'd5, 4'd6, OP_T_SUB};
            4'd5:    u = '{1'b1, 4'd0, 4'd1, OP_ACC_SUB};
            4'd6:    u = '{1'b0, 4'd3, 4'd7, OP_T_LOAD};
            4'd7:    u = '{1'b0, 4'd4, 4'd6, OP_T_SUB};
            default: u = '{1'b1, 4'd0, 4'd2, OP_ACC_ADD};
        endcase
        return u;
    endfunction

    function automatic logic [2:0] fml_mat(input logic [1:0] det, input logic [3:0] pos);
        logic [26:0] m;
        case (det)
            2'd0:    m = MAT_D;
            2'd1:    m = MAT_DA;
            default: m = MAT_DB;
        endcase
        return m[pos*3 +: 3];
    endfunction

    // Sum that takes the product of each accumulate multiply.
    function automatic logic [2:0] fml_acc_tgt(input logic [2:0] k);
        logic [2:0] t;
        case (k)
            3'd0:    t = 3'd2;
            3'd1:    t = 3'd3;
            3'd2:    t = 3'd4;
            3'd3:    t = 3'd6;
            default: t = 3'd7;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fringe_minimum_locator_top.sv @@
// ----------------------------------------------------------------------------
// fringe_minimum_locator_top: dip detector with least-squares vertex fit
// Tracks dips in an intensity stream with two thresholds, keeps moment sums
// over each dip and fits a parabola whose vertex is reported when it closes.
//
//   Channel   Dir   Payload                              Accepted when
//   s_axis    in    tdata: step_number, sample_level     tvalid & tready
//   m_axis    out   tdata: fringe_index, vertex_pos;     tvalid & tready
//                   tuser: fit_ok
//   apb       in    high_level, low_level, min_run       psel & penable & pwrite
//
// A sample inside a dip that fits the window starts five multiplies on the
// shared shift-add multiplier, each by the offset. A fit uses 27 multiplies
// of the same multiplier for three 3x3 determinants, then a restoring
// division with an integer pass and a fraction pass.
// s_axis_tready is low while an item is being worked on. A finished result
// waits in the output register, which does not stop the next request; a
// second finished fit holds the block until the first one has been taken.
// Reset is synchronous; it clears all sums and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module fringe_minimum_locator_top
    import fml_pkg::*;
#(
    parameter int MAX_SPAN  = 1024,
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] step_number, [47:32] sample_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] fringe_index, [79:32] vertex_pos
    output logic        m_axis_tuser,   // [0] fit_ok
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int XW = $clog2(MAX_SPAN);
    localparam logic signed [63:0] VMAX = 64'sd140737488355327;
    localparam logic signed [63:0] VMIN = -64'sd140737488355328;

    // Configuration
    logic [15:0]       r_high;
    logic [15:0]       r_low;
    logic [LOWC_W-1:0] r_minrun;

    // Control and dip state
    t_state            r_state, n_state;
    logic [LOWC_W-1:0] r_lowc, n_lowc;
    logic [31:0]       r_ws, n_ws;
    logic              r_ovf, n_ovf;
    logic [31:0]       r_fcnt, n_fcnt;
    logic [SUM_W-1:0]  r_sums [8];
    logic [SUM_W-1:0]  n_sums [8];
    logic [SUM_W-1:0]  r_snap [8];
    logic [SUM_W-1:0]  n_snap [8];
    logic              r_o_valid, n_o_valid;

    // Working registers
    logic [31:0]       r_fit_ws, n_fit_ws;
    logic [XW-1:0]     r_x, n_x;
    logic [15:0]       r_y, n_y;
    logic [2:0]        r_k, n_k;
    logic              r_is_low, n_is_low;
    logic [PROD_W-1:0] r_t, n_t;
    logic [PROD_W-1:0] r_detv [3];
    logic [PROD_W-1:0] n_detv [3];
    logic [1:0]        r_dsel, n_dsel;
    logic [3:0]        r_ph, n_ph;
    logic [PROD_W-1:0] r_opa, n_opa;
    logic [PROD_W-1:0] r_num, n_num;
    logic [PROD_W-1:0] r_den, n_den;
    logic [PROD_W-1:0] r_rem, n_rem;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [6:0]        r_cnt, n_cnt;
    logic [63:0]       r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [47:0]       r_vtx, n_vtx;
    logic              r_ok, n_ok;
    logic [31:0]       r_o_idx, n_o_idx;
    logic [47:0]       r_o_vtx, n_o_vtx;
    logic              r_o_ok, n_o_ok;

    // Combinational helpers
    logic [31:0]       in_step;
    logic [15:0]       in_y;
    logic              in_acc;
    logic [LOWC_W-1:0] need;
    logic              is_high;
    logic              is_low;
    logic              clr;
    logic [31:0]       xoff;
    logic [SUM_W-1:0]  n_eff;
    logic              acc_ok;
    logic [XW-1:0]     x_in;
    t_uop              uop;
    logic [3:0]        rd_pos;
    logic [2:0]        rd_idx;
    logic [SUM_W-1:0]  snap_rd;
    logic              div_in;
    logic [PROD_W-1:0] rem_sh;
    logic              ge;
    logic [PROD_W-1:0] rem_nx;
    logic [63:0]       rounded;
    logic signed [63:0] vsum;
    logic              out_free;
    logic [2:0]        tgt;
    logic [PROD_W-1:0] abs_da;
    logic [PROD_W-1:0] abs_db;
    t_mul_req          mul_req;
    t_mul_sts          mul_sts;

    fml_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_sts   (mul_sts)
    );

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high   <= 16'd19200;
            r_low    <= 16'd17920;
            r_minrun <= 10'd5;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_HIGH:   r_high   <= pwdata[15:0];
                REG_LOW:    r_low    <= pwdata[15:0];
                REG_MINRUN: r_minrun <= pwdata[LOWC_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HIGH:   prdata = {16'd0, r_high};
            REG_LOW:    prdata = {16'd0, r_low};
            REG_MINRUN: prdata = {22'd0, r_minrun};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    assign in_step = s_axis_tdata[31:0];
    assign in_y    = s_axis_tdata[47:32];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign need    = (r_minrun == '0) ? 10'd1 : r_minrun;
    assign is_high = in_y > r_high;
    assign is_low  = !is_high && (in_y < r_low);
    // The first low sample of a dip restarts the window at its own step.
    assign clr     = is_low && (r_lowc == '0);
    assign xoff    = in_step - (clr ? in_step : r_ws);
    assign n_eff   = clr ? '0 : r_sums[0];
    assign acc_ok  = (xoff < 32'(MAX_SPAN)) && (n_eff < 64'(MAX_SPAN));
    assign x_in    = xoff[XW-1:0];

    assign uop     = fml_uop(r_ph);
    assign rd_pos  = (r_state == S_FIT_LA) ? uop.a_pos : uop.b_pos;
    assign rd_idx  = fml_mat(r_dsel, rd_pos);
    assign snap_rd = r_snap[rd_idx];

    // One restoring division step, shared by the integer and fraction passes.
    assign div_in  = (r_state == S_DIV) ? r_num[PROD_W-1] : 1'b0;
    assign rem_sh  = {r_rem[PROD_W-2:0], div_in};
    assign ge      = rem_sh >= r_den;
    assign rem_nx  = ge ? (rem_sh - r_den) : rem_sh;

    assign rounded = (r_mag + 64'd1) >> 1;
    assign vsum    = (r_neg ? -$signed(rounded) : $signed(rounded))
                   + $signed(64'(r_fit_ws) << FRAC_BITS);

    assign out_free = !r_o_valid || m_axis_tready;
    assign tgt      = fml_acc_tgt(r_k);
    assign abs_da   = r_detv[1][PROD_W-1] ? (PROD_W'(0) - r_detv[1]) : r_detv[1];
    assign abs_db   = r_detv[2][PROD_W-1] ? (PROD_W'(0) - r_detv[2]) : r_detv[2];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_lowc    = r_lowc;
        n_ws      = r_ws;
        n_ovf     = r_ovf;
        n_fcnt    = r_fcnt;
        n_sums    = r_sums;
        n_snap    = r_snap;
        n_o_valid = r_o_valid && !m_axis_tready;
        n_fit_ws  = r_fit_ws;
        n_x       = r_x;
        n_y       = r_y;
        n_k       = r_k;
        n_is_low  = r_is_low;
        n_t       = r_t;
        n_detv    = r_detv;
        n_dsel    = r_dsel;
        n_ph      = r_ph;
        n_opa     = r_opa;
        n_num     = r_num;
        n_den     = r_den;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_vtx     = r_vtx;
        n_ok      = r_ok;
        n_o_idx   = r_o_idx;
        n_o_vtx   = r_o_vtx;
        n_o_ok    = r_o_ok;
        mul_req   = '{start: 1'b0, a: r_opa, b: '0};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (is_high) begin
                        if (r_lowc >= need) begin
                            n_fit_ws = r_ws;
                            if (r_ovf) begin
                                n_ok    = 1'b0;
                                n_vtx   = '0;
                                n_state = S_OUT;
                            end else begin
                                n_dsel  = 2'd0;
                                n_ph    = 4'd0;
                                n_state = S_FIT_LA;
                            end
                        end
                        n_ws   = in_step;
                        n_lowc = '0;
                    end else if (is_low || (r_lowc != '0)) begin
                        if (clr) begin
                            n_ws  = in_step;
                            n_ovf = 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                n_sums[i] = '0;
                            end
                        end
                        if (is_low && (r_lowc != LOWC_MAX)) begin
                            n_lowc = r_lowc + 1'b1;
                        end
                        if (acc_ok) begin
                            n_sums[0] = n_sums[0] + 64'd1;
                            n_sums[1] = n_sums[1] + 64'(x_in);
                            n_sums[5] = n_sums[5] + 64'(in_y);
                            n_x       = x_in;
                            n_y       = in_y;
                            n_k       = 3'd0;
                            n_is_low  = is_low;
                            mul_req   = '{start: 1'b1, a: PROD_W'(x_in), b: SUM_W'(x_in)};
                            n_state   = S_ACC_MUL;
                        end else if (is_low) begin
                            n_ovf  = 1'b1;
                            n_snap = n_sums;
                        end
                    end
                end
            end

            S_ACC_MUL: begin
                if (mul_sts.done) begin
                    n_sums[tgt] = r_sums[tgt] + mul_sts.prod[SUM_W-1:0];
                    if (r_k == 3'd4) begin
                        if (r_is_low) begin
                            n_snap = n_sums;
                        end
                        n_state = S_IDLE;
                    end else begin
                        // x^2, x^3, x^4 chain on the previous product; y*x restarts.
                        mul_req = '{start: 1'b1,
                                    a: (r_k == 3'd2) ? PROD_W'(r_y) : mul_sts.prod,
                                    b: SUM_W'(r_x)};
                        n_k = r_k + 3'd1;
                    end
                end
            end

            S_FIT_LA: begin
                n_opa   = uop.a_is_t ? r_t : PROD_W'(snap_rd);
                n_state = S_FIT_LB;
            end

            S_FIT_LB: begin
                mul_req = '{start: 1'b1, a: r_opa, b: snap_rd};
                n_state = S_FIT_MUL;
            end

            S_FIT_MUL: begin
                if (mul_sts.done) begin
                    case (uop.op)
                        OP_T_LOAD:   n_t = mul_sts.prod;
                        OP_T_SUB:    n_t = r_t - mul_sts.prod;
                        OP_ACC_LOAD: n_detv[r_dsel] = mul_sts.prod;
                        OP_ACC_SUB:  n_detv[r_dsel] = r_detv[r_dsel] - mul_sts.prod;
                        OP_ACC_ADD:  n_detv[r_dsel] = r_detv[r_dsel] + mul_sts.prod;
                        default:     n_t = r_t;
                    endcase
                    if (r_ph == 4'd8) begin
                        n_ph = 4'd0;
                        if (r_dsel == 2'd2) begin
                            n_state = S_CHK;
                        end else begin
                            n_dsel  = r_dsel + 2'd1;
                            n_state = S_FIT_LA;
                        end
                    end else begin
                        n_ph    = r_ph + 4'd1;
                        n_state = S_FIT_LA;
                    end
                end
            end

            S_CHK: begin
                if ((r_detv[0] == '0) || (r_detv[1] == '0)) begin
                    n_ok    = 1'b0;
                    n_vtx   = '0;
                    n_state = S_OUT;
                end else begin
                    n_num   = abs_db;
                    n_den   = {abs_da[PROD_W-2:0], 1'b0};
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    // Same signs give a negative offset from the window start.
                    n_neg   = (r_detv[2][PROD_W-1] == r_detv[1][PROD_W-1]);
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                n_rem = rem_nx;
                n_quo = {r_quo[PROD_W-2:0], ge};
                n_num = {r_num[PROD_W-2:0], 1'b0};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd127) begin
                    n_state = S_CLAMP;
                end
            end

            S_CLAMP: begin
                n_mag   = ((r_quo[PROD_W-1:64] != '0) || (r_quo[63:0] > MAG_LIM)) ?
                          MAG_LIM : r_quo[63:0];
                n_cnt   = '0;
                n_state = S_FRAC;
            end

            S_FRAC: begin
                n_rem = rem_nx;
                n_mag = {r_mag[62:0], ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(FRAC_BITS)) begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (vsum > VMAX) begin
                    n_vtx = VMAX[47:0];
                end else if (vsum < VMIN) begin
                    n_vtx = VMIN[47:0];
                end else begin
                    n_vtx = vsum[47:0];
                end
                n_ok    = 1'b1;
                n_state = S_OUT;
            end

            S_OUT: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_o_idx   = r_fcnt;
                    n_o_vtx   = r_vtx;
                    n_o_ok    = r_ok;
                    n_fcnt    = r_fcnt + 32'd1;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lowc    <= '0;
            r_ws      <= '0;
            r_ovf     <= 1'b0;
            r_fcnt    <= '0;
            r_o_valid <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_sums[i] <= '0;
                r_snap[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_lowc    <= n_lowc;
            r_ws      <= n_ws;
            r_ovf     <= n_ovf;
            r_fcnt    <= n_fcnt;
            r_o_valid <= n_o_valid;
            r_sums    <= n_sums;
            r_snap    <= n_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fit_ws <= n_fit_ws;
        r_x      <= n_x;
        r_y      <= n_y;
        r_k      <= n_k;
        r_is_low <= n_is_low;
        r_t      <= n_t;
        r_detv   <= n_detv;
        r_dsel   <= n_dsel;
        r_ph     <= n_ph;
        r_opa    <= n_opa;
        r_num    <= n_num;
        r_den    <= n_den;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_vtx    <= n_vtx;
        r_ok     <= n_ok;
        r_o_idx  <= n_o_idx;
        r_o_vtx  <= n_o_vtx;
        r_o_ok   <= n_o_ok;
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_vtx, r_o_idx};
    assign m_axis_tuser  = r_o_ok;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mul_sts.busy)
        else $error("multiplier still busy while the block takes requests");

    a_fit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (r_fcnt == $past(r_fcnt) + 32'd1))
        else $error("fit counter did not advance with a delivered result");

    a_frac_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAC) |-> (r_cnt <= 7'(FRAC_BITS)))
        else $error("fraction pass ran past its length");

endmodule

`default_nettype wire

@@ rtl/fml_mul.sv @@
// ----------------------------------------------------------------------------
// fml_mul: shared shift-add multiplier
// Multiplies a 128-bit two's complement operand by a 64-bit unsigned one,
// one multiplier bit a cycle, stopping once the remaining bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fml_mul
    import fml_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_sts o_sts
);

    logic              r_busy;
    logic [PROD_W-1:0] r_ma;
    logic [SUM_W-1:0]  r_mb;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_mb == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma   <= i_req.a;
            r_mb   <= i_req.b;
            r_prod <= '0;
        end else if (r_busy && (r_mb != '0)) begin
            if (r_mb[0]) begin
                r_prod <= r_prod + r_ma;
            end
            r_ma <= {r_ma[PROD_W-2:0], 1'b0};
            r_mb <= {1'b0, r_mb[SUM_W-1:1]};
        end
    end

    assign o_sts = '{busy: r_busy, done: r_busy && (r_mb == '0), prod: r_prod};

endmodule

`default_nettype wire
